/* src/pmds_pkg.sv */
// Shared types and constants for the potentiometer percent / mode / direction selector.
// No dependencies; imported by every module of the block.
package pmds_pkg;

  // register file addressing: 8 registers at byte offsets 4*i
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int PCT_W = 7;

  // restoring divider: for a non-empty span the quotient never exceeds 100, so seven bits suffice
  localparam int DIV_STEPS = 7;
  localparam logic [2:0] STEP_LAST = 3'(DIV_STEPS - 1);
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // register indexes
  localparam logic [2:0] REG_SPAN_MIN = 3'd0;
  localparam logic [2:0] REG_SPAN_MAX = 3'd1;
  localparam logic [2:0] REG_ERR_THR = 3'd2;
  localparam logic [2:0] REG_INACT_THR = 3'd3;
  localparam logic [2:0] REG_CW_LOW = 3'd4;
  localparam logic [2:0] REG_CW_HIGH = 3'd5;
  localparam logic [2:0] REG_CCW_LOW = 3'd6;
  localparam logic [2:0] REG_CCW_HIGH = 3'd7;

  // reset value of the span top, trimmed to the sample width where used
  localparam int SPAN_MAX_RST = 4095;

  // reset values of the percent registers
  localparam logic [PCT_W-1:0] ERR_THR_RST = 7'd80;
  localparam logic [PCT_W-1:0] INACT_THR_RST = 7'd20;
  localparam logic [PCT_W-1:0] CW_LOW_RST = 7'd30;
  localparam logic [PCT_W-1:0] CW_HIGH_RST = 7'd40;
  localparam logic [PCT_W-1:0] CCW_LOW_RST = 7'd60;
  localparam logic [PCT_W-1:0] CCW_HIGH_RST = 7'd70;

  // mode codes
  localparam logic [1:0] MODE_WORK = 2'd0;
  localparam logic [1:0] MODE_INACTIVE = 2'd1;
  localparam logic [1:0] MODE_ERROR = 2'd2;

  // direction codes
  localparam logic [1:0] DIR_INACTIVE = 2'd0;
  localparam logic [1:0] DIR_CW = 2'd1;
  localparam logic [1:0] DIR_CCW = 2'd2;

  // percent-domain settings
  typedef struct packed {
    logic [PCT_W-1:0] err_thr;
    logic [PCT_W-1:0] inact_thr;
    logic [PCT_W-1:0] cw_low;
    logic [PCT_W-1:0] cw_high;
    logic [PCT_W-1:0] ccw_low;
    logic [PCT_W-1:0] ccw_high;
  } pct_cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture clamped sample and span
    logic mul;     // form dividend num*100 + range/2
    logic step;    // one restoring divide step
    logic finish;  // classify and load output word
  } dp_cmd_t;

endpackage

/* src/pmds_regs.sv */
// APB-style configuration registers: span bounds, thresholds and windows.
// Depends on pmds_pkg.
module pmds_regs
  import pmds_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic [SAMPLE_BITS-1:0] span_min,
  output logic [SAMPLE_BITS-1:0] span_max,
  output pct_cfg_t               pct_cfg
);

  logic [SAMPLE_BITS-1:0] span_min_r;
  logic [SAMPLE_BITS-1:0] span_max_r;
  pct_cfg_t               pct_cfg_r;
  logic [2:0]             idx;
  logic                   wr_en;

  assign idx   = paddr[4:2];
  assign wr_en = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_min_r          <= '0;
      span_max_r          <= SAMPLE_BITS'(SPAN_MAX_RST);
      pct_cfg_r.err_thr   <= ERR_THR_RST;
      pct_cfg_r.inact_thr <= INACT_THR_RST;
      pct_cfg_r.cw_low    <= CW_LOW_RST;
      pct_cfg_r.cw_high   <= CW_HIGH_RST;
      pct_cfg_r.ccw_low   <= CCW_LOW_RST;
      pct_cfg_r.ccw_high  <= CCW_HIGH_RST;
    end else if (wr_en) begin
      case (idx)
        REG_SPAN_MIN:  span_min_r          <= pwdata[SAMPLE_BITS-1:0];
        REG_SPAN_MAX:  span_max_r          <= pwdata[SAMPLE_BITS-1:0];
        REG_ERR_THR:   pct_cfg_r.err_thr   <= pwdata[PCT_W-1:0];
        REG_INACT_THR: pct_cfg_r.inact_thr <= pwdata[PCT_W-1:0];
        REG_CW_LOW:    pct_cfg_r.cw_low    <= pwdata[PCT_W-1:0];
        REG_CW_HIGH:   pct_cfg_r.cw_high   <= pwdata[PCT_W-1:0];
        REG_CCW_LOW:   pct_cfg_r.ccw_low   <= pwdata[PCT_W-1:0];
        REG_CCW_HIGH:  pct_cfg_r.ccw_high  <= pwdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_SPAN_MIN:  prdata = DATA_W'(span_min_r);
      REG_SPAN_MAX:  prdata = DATA_W'(span_max_r);
      REG_ERR_THR:   prdata = DATA_W'(pct_cfg_r.err_thr);
      REG_INACT_THR: prdata = DATA_W'(pct_cfg_r.inact_thr);
      REG_CW_LOW:    prdata = DATA_W'(pct_cfg_r.cw_low);
      REG_CW_HIGH:   prdata = DATA_W'(pct_cfg_r.cw_high);
      REG_CCW_LOW:   prdata = DATA_W'(pct_cfg_r.ccw_low);
      REG_CCW_HIGH:  prdata = DATA_W'(pct_cfg_r.ccw_high);
      default:       prdata = '0;
    endcase
  end

  assign span_min = span_min_r;
  assign span_max = span_max_r;
  assign pct_cfg  = pct_cfg_r;

endmodule

/* src/pmds_ctrl.sv */
// Controller: sequences load, multiply, divide steps and finish; owns the output valid.
// Depends on pmds_pkg.
module pmds_ctrl
  import pmds_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 3'd1;
        if (cnt_r == STEP_LAST) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* src/pmds_dp.sv */
// Datapath: clamp, scale by 100, restoring divide, mode/direction classify, output word.
// Depends on pmds_pkg.
module pmds_dp
  import pmds_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  input  logic [SAMPLE_BITS-1:0] adc_sample,
  input  logic [SAMPLE_BITS-1:0] span_min,
  input  logic [SAMPLE_BITS-1:0] span_max,
  input  pct_cfg_t               pct_cfg,
  output logic [PCT_W-1:0]       percent,
  output logic [1:0]             mode,
  output logic [1:0]             direction
);

  localparam int DW = SAMPLE_BITS + PCT_W;

  logic [SAMPLE_BITS-1:0] num_r, range_r;
  logic                   empty_r;
  logic [DW-1:0]          rem_r, dsh_r;
  logic [PCT_W-1:0]       quo_r;
  logic [1:0]             dir_r, dir_nxt;
  logic [PCT_W-1:0]       pct_r;
  logic [1:0]             mode_r;

  logic [SAMPLE_BITS-1:0] clamped;
  logic                   ge;
  logic [PCT_W-1:0]       pct;
  logic [1:0]             mode_c;
  logic                   in_cw, in_ccw;

  // clamp sample into span
  always_comb begin
    if (adc_sample < span_min) begin
      clamped = span_min;
    end else if (adc_sample > span_max) begin
      clamped = span_max;
    end else begin
      clamped = adc_sample;
    end
  end

  assign ge = (rem_r >= dsh_r);

  // percent clamp and classification
  always_comb begin
    if (empty_r) begin
      pct = '0;
    end else if (quo_r > PCT_MAX) begin
      pct = PCT_MAX;
    end else begin
      pct = quo_r;
    end
    if (pct >= pct_cfg.err_thr) begin
      mode_c = MODE_ERROR;
    end else if (pct >= pct_cfg.inact_thr) begin
      mode_c = MODE_INACTIVE;
    end else begin
      mode_c = MODE_WORK;
    end
    in_cw   = (pct_cfg.cw_low <= pct) && (pct <= pct_cfg.cw_high);
    in_ccw  = (pct_cfg.ccw_low <= pct) && (pct <= pct_cfg.ccw_high);
    dir_nxt = dir_r;
    if (mode_c == MODE_WORK) begin
      if (in_cw) begin
        dir_nxt = DIR_CW;
      end else if (in_ccw) begin
        dir_nxt = DIR_CCW;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r   <= clamped - span_min;
      range_r <= span_max - span_min;
      empty_r <= (span_max <= span_min);
    end
    if (cmd.mul) begin
      rem_r <= DW'(num_r) * DW'(PCT_MAX) + DW'(range_r >> 1);
      dsh_r <= DW'(range_r) << (DIV_STEPS - 1);
      quo_r <= '0;
    end else if (cmd.step) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r <= dsh_r >> 1;
      quo_r <= {quo_r[PCT_W-2:0], ge};
    end
    if (cmd.finish) begin
      pct_r  <= pct;
      mode_r <= mode_c;
    end
  end

  // held motor direction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_INACTIVE;
    end else if (cmd.finish) begin
      dir_r <= dir_nxt;
    end
  end

  assign percent   = pct_r;
  assign mode      = mode_r;
  assign direction = dir_r;

endmodule

/* src/pot_percent_mode_direction_selector.sv */
// Top level of the potentiometer percent / mode / direction selector.
// Depends on pmds_pkg, pmds_regs, pmds_ctrl, pmds_dp.
//
//   port group   direction  word
//   in_*         input      adc_sample (valid/ready)
//   out_*        output     percent, mode, direction (valid/ready)
//   p*           APB        eight configuration registers at 4*i
//
// A word goes from its accepting edge to out_valid through the load at that edge,
// then one multiply, seven steps of the restoring divider and one finish.
// One word is worked at a time; in_ready returns with the finish, so a new word
// is accepted only after the earlier one has reached its finish.
// Reset (rst_n low, synchronous) restores register defaults and clears direction.
// A stalled result stays in the output register while the next word is accepted
// and computed; the finish waits only if the earlier result is still not taken.
module pot_percent_mode_direction_selector
  import pmds_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_adc_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [PCT_W-1:0]       out_percent,
  output logic [1:0]             out_mode,
  output logic [1:0]             out_direction,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  logic [SAMPLE_BITS-1:0] span_min, span_max;
  pct_cfg_t               pct_cfg;
  dp_cmd_t                cmd;

  assign pready = 1'b1;

  pmds_regs #(.SAMPLE_BITS(SAMPLE_BITS)) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .span_min (span_min),
    .span_max (span_max),
    .pct_cfg  (pct_cfg)
  );

  pmds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  pmds_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .adc_sample (in_adc_sample),
    .span_min   (span_min),
    .span_max   (span_max),
    .pct_cfg    (pct_cfg),
    .percent    (out_percent),
    .mode       (out_mode),
    .direction  (out_direction)
  );

`ifndef SYNTHESIS
  // percent never exceeds full scale
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_percent <= PCT_MAX)
    else $error("percent above 100");

  // one word in flight: accept drops ready
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while busy");

  // error mode only at or above the error threshold
  a_err_mode: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && out_mode == MODE_ERROR |-> out_percent >= pct_cfg.err_thr)
    else $error("error mode below threshold");

  // direction only changes on a work-mode result
  a_dir_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && out_mode != MODE_WORK && $past(rst_n) |->
      out_direction == $past(out_direction))
    else $error("direction changed outside work mode");
`endif

endmodule

/* tb/tb.sv */
// Self-checking bench for pot_percent_mode_direction_selector: drives ADC words and APB writes,
// predicts percent, mode and held direction per word. Depends on pmds_pkg and the block's RTL.
module tb;
  import pmds_pkg::*;

  localparam int SMP_W = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_LEN = 400;
  localparam int DRAIN_CYCLES = 12;
  localparam int IDLE_PCT = 14;
  localparam int RAND_PHASES = 14;
  localparam int PHASE_WORDS = 105;

  typedef enum logic [1:0] {PACE_RANDOM, PACE_STEADY, PACE_HOLD} pace_t;

  typedef struct packed {
    logic [PCT_W-1:0] percent;
    logic [1:0]       mode;
    logic [1:0]       direction;
  } pot_reading_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [SMP_W-1:0]  in_adc_sample = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [PCT_W-1:0]  out_percent;
  logic [1:0]        out_mode;
  logic [1:0]        out_direction;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // shadow of the register file and the held direction
  logic [SMP_W-1:0] span_lo = '0;
  logic [SMP_W-1:0] span_hi = 12'd4095;
  pct_cfg_t         pct_cfg = '{err_thr: ERR_THR_RST, inact_thr: INACT_THR_RST,
                                cw_low: CW_LOW_RST, cw_high: CW_HIGH_RST,
                                ccw_low: CCW_LOW_RST, ccw_high: CCW_HIGH_RST};
  logic [1:0]       held_dir = DIR_INACTIVE;

  logic [SMP_W-1:0] sample_queue[$];
  pot_reading_t     readings_due[$];

  pace_t tx_pace = PACE_RANDOM;
  pace_t rx_pace = PACE_RANDOM;
  int    hold_cycles = 0;
  logic  hold_done = 1'b0;

  int mismatches = 0;
  int words_sent = 0;
  int readings_checked = 0;
  int settings_used = 0;
  int cycle_count = 0;

  pot_percent_mode_direction_selector dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_adc_sample (in_adc_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_percent   (out_percent),
    .out_mode      (out_mode),
    .out_direction (out_direction),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // scale a sample into the span, classify it and advance the held direction
  function automatic pot_reading_t scale_and_select(input logic [SMP_W-1:0] smp);
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  v;
    int unsigned  range;
    int unsigned  num;
    int unsigned  pct;
    pot_reading_t r;
    lo = span_lo;
    hi = span_hi;
    v = smp;
    pct = 0;
    if (hi > lo) begin
      if (v < lo) v = lo;
      else if (v > hi) v = hi;
      range = hi - lo;
      num = v - lo;
      pct = (num / range) * 100 + ((num % range) * 100 + range / 2) / range;
      if (pct > 100) pct = 100;
    end
    r.percent = pct[PCT_W-1:0];
    if (pct >= pct_cfg.err_thr) r.mode = MODE_ERROR;
    else if (pct >= pct_cfg.inact_thr) r.mode = MODE_INACTIVE;
    else r.mode = MODE_WORK;
    // only work mode moves the direction; clockwise wins on overlap
    if (r.mode == MODE_WORK) begin
      if (pct_cfg.cw_low <= pct && pct <= pct_cfg.cw_high) held_dir = DIR_CW;
      else if (pct_cfg.ccw_low <= pct && pct <= pct_cfg.ccw_high) held_dir = DIR_CCW;
    end
    r.direction = held_dir;
    return r;
  endfunction

  // sender: predicts on acceptance, then offers the next queued word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        readings_due.push_back(scale_and_select(in_adc_sample));
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        if (sample_queue.size() != 0 &&
            (tx_pace != PACE_RANDOM || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_adc_sample <= sample_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, steady ready or one long hold counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_pace == PACE_HOLD && !hold_done) begin
      if (hold_cycles == HOLD_LEN) begin
        hold_done <= 1'b1;
        out_ready <= 1'b1;
      end else begin
        hold_cycles <= hold_cycles + 1;
        out_ready <= 1'b0;
      end
    end else begin
      out_ready <= (rx_pace != PACE_RANDOM) || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin : monitor
    pot_reading_t want;
    if (rst_n && out_valid && out_ready) begin
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected result percent %0d mode %0d direction %0d",
                 $time, out_percent, out_mode, out_direction);
        mismatches++;
      end else begin
        want = readings_due.pop_front();
        readings_checked++;
        if (out_percent !== want.percent) begin
          $display("%0t: percent expected %0d actual %0d", $time, want.percent, out_percent);
          mismatches++;
        end
        if (out_mode !== want.mode) begin
          $display("%0t: mode expected %0d actual %0d", $time, want.mode, out_mode);
          mismatches++;
        end
        if (out_direction !== want.direction) begin
          $display("%0t: direction expected %0d actual %0d",
                   $time, want.direction, out_direction);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, readings_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  // APB write: setup cycle, access cycle, then mirror the register
  task automatic reg_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SPAN_MIN:  span_lo = val[SMP_W-1:0];
      REG_SPAN_MAX:  span_hi = val[SMP_W-1:0];
      REG_ERR_THR:   pct_cfg.err_thr = val[PCT_W-1:0];
      REG_INACT_THR: pct_cfg.inact_thr = val[PCT_W-1:0];
      REG_CW_LOW:    pct_cfg.cw_low = val[PCT_W-1:0];
      REG_CW_HIGH:   pct_cfg.cw_high = val[PCT_W-1:0];
      REG_CCW_LOW:   pct_cfg.ccw_low = val[PCT_W-1:0];
      REG_CCW_HIGH:  pct_cfg.ccw_high = val[PCT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_config(input int lo, input int hi, input int err, input int inact,
                              input int cwl, input int cwh, input int ccwl, input int ccwh);
    reg_write(REG_SPAN_MIN, DATA_W'(lo));
    reg_write(REG_SPAN_MAX, DATA_W'(hi));
    reg_write(REG_ERR_THR, DATA_W'(err));
    reg_write(REG_INACT_THR, DATA_W'(inact));
    reg_write(REG_CW_LOW, DATA_W'(cwl));
    reg_write(REG_CW_HIGH, DATA_W'(cwh));
    reg_write(REG_CCW_LOW, DATA_W'(ccwl));
    reg_write(REG_CCW_HIGH, DATA_W'(ccwh));
    settings_used++;
    @(negedge clk);
  endtask

  // hold off new words until every result is back, then let the block settle
  task automatic drain();
    @(negedge clk);
    while (sample_queue.size() != 0 || in_valid || readings_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int lo;
    int hi;
    int err;
    int inact;
    int cwl;
    int cwh;
    int ccwl;
    int ccwh;
    int tmp;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: extremes and midpoint of the sample
    settings_used++;
    sample_queue = '{12'd0, 12'd4095, 12'd2048, 12'd1};
    drain();

    // clamping below and above the span, thresholds above 100, both windows
    write_config(1000, 3000, 127, 127, 30, 40, 60, 70);
    sample_queue = '{12'd0, 12'd4095, 12'd1000, 12'd3000, 12'd1700, 12'd2300, 12'd2500};
    drain();

    // empty span, zero thresholds
    write_config(2000, 2000, 0, 0, 30, 40, 60, 70);
    sample_queue = '{12'd0, 12'd4095};
    drain();

    // inverted span, inverted clockwise window
    write_config(4095, 0, 101, 50, 50, 10, 0, 0);
    sample_queue = '{12'd123};
    drain();

    // one-count span and overlapping windows
    write_config(0, 1, 100, 100, 0, 100, 0, 100);
    sample_queue = '{12'd0, 12'd1};
    drain();

    // clockwise window out of reach, top of range hits error at 100
    write_config(0, 4095, 100, 100, 101, 127, 0, 100);
    sample_queue = '{12'd4000, 12'd4095};
    drain();

    // random settings, each phase drained before the next write
    for (int p = 0; p < RAND_PHASES; p++) begin
      lo = $urandom_range(4095);
      hi = $urandom_range(4095);
      if (lo > hi && $urandom_range(9) != 0) begin
        tmp = lo;
        lo = hi;
        hi = tmp;
      end
      case ($urandom_range(7))
        0: begin
          lo = 0;
          hi = 4095;
        end
        1: hi = (lo + $urandom_range(1, 9) > 4095) ? 4095 : lo + $urandom_range(1, 9);
        default: ;
      endcase
      err = $urandom_range(40, 127);
      inact = $urandom_range(20, 127);
      cwl = $urandom_range(100);
      cwh = cwl + $urandom_range(27);
      ccwl = $urandom_range(100);
      ccwh = ccwl + $urandom_range(27);
      if ($urandom_range(5) == 0) cwh = $urandom_range(127);
      if ($urandom_range(5) == 0) ccwl = $urandom_range(127);
      if (p == 0) begin
        lo = 0;
        hi = 4095;
        err = 127;
        inact = 127;
        cwl = 0;
        cwh = 50;
        ccwl = 51;
        ccwh = 127;
      end
      write_config(lo, hi, err, inact, cwl, cwh, ccwl, ccwh);
      tx_pace = (p == 1 || p == 2) ? PACE_STEADY : PACE_RANDOM;
      rx_pace = (p == 1) ? PACE_HOLD : (p == 2) ? PACE_STEADY : PACE_RANDOM;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if ($urandom_range(9) < 7 && lo < hi)
          sample_queue.push_back(SMP_W'($urandom_range(lo, hi)));
        else
          sample_queue.push_back(SMP_W'($urandom_range(4095)));
      end
      drain();
    end

    if (readings_due.size() != 0) mismatches++;
    $display("Run covered %0d ADC words and %0d checked results over %0d register settings,",
             words_sent, readings_checked, settings_used);
    $display("with a %0d-cycle output stall and drained pauses between settings.", HOLD_LEN);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
